// ===== rtl/dwes_pkg.sv =====
// Shared widths, constants and sequencer type for the dual wheel encoder speed unit.
`default_nettype none

package dwes_pkg;

    localparam int unsigned TS_W    = 32;     // timestamp port width
    localparam int unsigned ND_W    = 16;     // notch distance register width
    localparam int unsigned SPEED_W = 26;     // speed in mm/s
    localparam int unsigned DIST_W  = 48;     // distance in um

    localparam logic [ND_W-1:0]    ND_RESET = ND_W'(10525);
    localparam logic [SPEED_W-1:0] UM_TO_MM = SPEED_W'(1000);

    localparam logic KIND_NOTCH = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/dwes_div.sv =====
// Restoring divider, one quotient bit per cycle, for the speed quotient.
`default_nettype none

module dwes_div #(
    parameter int unsigned DIVISOR_W = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [dwes_pkg::SPEED_W-1:0]     dividend,
    input  wire logic [DIVISOR_W-1:0]             divisor,
    output logic                                  done,
    output logic      [dwes_pkg::SPEED_W-1:0]     quotient
);

    localparam int unsigned QW    = dwes_pkg::SPEED_W;
    localparam int unsigned CNT_W = $clog2(QW + 1);

    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] rem_next;
    logic [QW-1:0]        quo_reg;
    logic [QW-1:0]        quo_next;
    logic [DIVISOR_W-1:0] dvs_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIVISOR_W:0]   rem_sh;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;

    // Shift in the next dividend bit and trial-subtract the divisor
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[QW-1]};
        diff     = rem_sh - {1'b0, dvs_reg};
        fits     = (rem_sh >= {1'b0, dvs_reg});
        rem_next = fits ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
        quo_next = {quo_reg[QW-2:0], fits};
    end

    // Control: load on start, step until all quotient bits are out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder, quotient and held divisor
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/dual_wheel_encoder_speed.sv =====
// Top level of the dual wheel encoder speed unit: state, sequencer and ports.
//
//  channel | handshake           | word
//  --------+---------------------+------------------------------------------------
//  in      | in_valid / in_stall | kind, channel, timestamp_us
//  out     | out_valid/out_stall | speed_left, speed_right, distance_left/right
//  cfg     | cfg_valid/cfg_ready | cfg_data (notch_distance_um)
//
// A tick or a first notch has its result word offered in the cycle after accept;
// a counted notch first runs the restoring divider in ST_DIV, then offers its word.
// The next word can be taken in the cycle after the result word has been taken.
// in_stall stays high from accept until the result word has been taken.
// Reset clears all wheel state and loads the notch distance with 10525 um.
// out_stall holds the result word unchanged; nothing new is taken meanwhile.
`default_nettype none

module dual_wheel_encoder_speed #(
    parameter int unsigned TIME_BITS = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // input word
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             kind,
    input  wire logic                             channel,
    input  wire logic [dwes_pkg::TS_W-1:0]        timestamp_us,
    // result word
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic      [dwes_pkg::SPEED_W-1:0]     speed_left,
    output logic      [dwes_pkg::SPEED_W-1:0]     speed_right,
    output logic      [dwes_pkg::DIST_W-1:0]      distance_left,
    output logic      [dwes_pkg::DIST_W-1:0]      distance_right,
    // configuration
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [dwes_pkg::ND_W-1:0]        cfg_data
);

    localparam int unsigned SW = dwes_pkg::SPEED_W;
    localparam int unsigned DW = dwes_pkg::DIST_W;
    localparam int unsigned NW = dwes_pkg::ND_W;

    dwes_pkg::seq_state_t state_reg;
    dwes_pkg::seq_state_t state_next;

    logic                 ch_reg;
    logic [NW-1:0]        nd_reg;
    logic [TIME_BITS-1:0] last_reg  [2];
    logic [SW-1:0]        speed_reg [2];
    logic [DW-1:0]        dist_reg  [2];
    logic [1:0]           seen_reg;
    logic [1:0]           moved_reg;

    logic [TIME_BITS-1:0] t_in;
    logic [TIME_BITS-1:0] period;
    logic [TIME_BITS-1:0] divisor;
    logic [SW-1:0]        scaled;
    logic                 accept;
    logic                 is_notch;
    logic                 div_start;
    logic                 div_done;
    logic [SW-1:0]        div_quo;

    // Fit the timestamp to the time width
    generate
        if (TIME_BITS > dwes_pkg::TS_W)
        begin : g_time_wide
            assign t_in = {{(TIME_BITS - dwes_pkg::TS_W){1'b0}}, timestamp_us};
        end
        else
        begin : g_time_narrow
            assign t_in = timestamp_us[TIME_BITS-1:0];
        end
    endgenerate

    // Handshakes
    assign in_stall  = (state_reg != dwes_pkg::ST_IDLE);
    assign out_valid = (state_reg == dwes_pkg::ST_OUT);
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !in_stall;
    assign is_notch  = (kind == dwes_pkg::KIND_NOTCH);
    assign div_start = accept && is_notch && seen_reg[channel];

    // Period since the last notch; a zero period divides as one microsecond
    always_comb
    begin
        period  = t_in - last_reg[channel];
        divisor = (period == '0) ? TIME_BITS'(1) : period;
        scaled  = SW'(SW'(nd_reg) * dwes_pkg::UM_TO_MM);
    end

    dwes_div #(
        .DIVISOR_W (TIME_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (scaled),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dwes_pkg::ST_IDLE:
            begin
                if (div_start)
                    state_next = dwes_pkg::ST_DIV;
                else if (accept)
                    state_next = dwes_pkg::ST_OUT;
            end
            dwes_pkg::ST_DIV:
            begin
                if (div_done)
                    state_next = dwes_pkg::ST_OUT;
            end
            dwes_pkg::ST_OUT:
            begin
                if (!out_stall)
                    state_next = dwes_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dwes_pkg::ST_IDLE;
            end
        endcase
    end

    // State register, notch distance and wheel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dwes_pkg::ST_IDLE;
            ch_reg       <= 1'b0;
            nd_reg       <= dwes_pkg::ND_RESET;
            last_reg[0]  <= '0;
            last_reg[1]  <= '0;
            speed_reg[0] <= '0;
            speed_reg[1] <= '0;
            dist_reg[0]  <= '0;
            dist_reg[1]  <= '0;
            seen_reg     <= '0;
            moved_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
                nd_reg <= cfg_data;

            if (accept)
            begin
                if (is_notch)
                begin
                    // Record the notch; count it when an earlier one exists
                    ch_reg             <= channel;
                    last_reg[channel]  <= t_in;
                    seen_reg[channel]  <= 1'b1;
                    if (seen_reg[channel])
                    begin
                        dist_reg[channel]  <= dist_reg[channel] + DW'(nd_reg);
                        moved_reg[channel] <= 1'b1;
                    end
                end
                else
                begin
                    // Drop the speed of any wheel that has not moved
                    if (!moved_reg[0])
                        speed_reg[0] <= '0;
                    if (!moved_reg[1])
                        speed_reg[1] <= '0;
                    moved_reg <= '0;
                end
            end

            // Take the finished quotient
            if (state_reg == dwes_pkg::ST_DIV && div_done)
                speed_reg[ch_reg] <= div_quo;
        end
    end

    // Result word straight from the wheel state
    assign speed_left     = speed_reg[0];
    assign speed_right    = speed_reg[1];
    assign distance_left  = dist_reg[0];
    assign distance_right = dist_reg[1];

endmodule

`default_nettype wire
